### hdl/size_class_buffer_recycler_core_defines.svh
// Assertion macros used by the buffer recycler pool store.
`ifndef SIZE_CLASS_BUFFER_RECYCLER_CORE_DEFINES_SVH
`define SIZE_CLASS_BUFFER_RECYCLER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCBR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCBR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/scbr_pkg.sv
// Shared types and defaults for the size class buffer recycler.
package scbr_pkg;

   // Default configuration of the pool.
   localparam int SCBR_MIN_CLASS_POWER = 8;
   localparam int SCBR_MAX_CLASS_POWER = 28;
   localparam int SCBR_STACK_DEPTH     = 8;
   localparam int SCBR_HANDLE_WIDTH    = 16;

   // Fixed field widths of the item ports.
   localparam int SCBR_SIZE_W        = 32;
   localparam int SCBR_HANDLE_PORT_W = 16;
   localparam int SCBR_COUNT_W       = 32;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_HIT     = 3'd0,
      STATUS_MISS    = 3'd1,
      STATUS_BYPASS  = 3'd2,
      STATUS_STORED  = 3'd3,
      STATUS_DROPPED = 3'd4,
      STATUS_NULL    = 3'd5
   } status_type;

   // Stack operation issued to the pool store.
   typedef struct packed {
      logic push;
      logic pop;
   } store_cmd_type;

   // Occupancy of the addressed class stack.
   typedef struct packed {
      logic has_entry;
      logic has_room;
   } store_stat_type;

endpackage

### hdl/scbr_class_decode.sv
// Size to class decoder: round-up class and exact class match.
module scbr_class_decode
   import scbr_pkg::*;
#(
   parameter int MIN_CLASS_POWER = SCBR_MIN_CLASS_POWER,
   parameter int MAX_CLASS_POWER = SCBR_MAX_CLASS_POWER,
   parameter int CLS_W           = 5
) (
   input  logic [SCBR_SIZE_W-1:0] size,
   output logic                   fit_found,
   output logic [CLS_W-1:0]       fit_cls,
   output logic [SCBR_SIZE_W-1:0] fit_bytes,
   output logic                   exact_found,
   output logic [CLS_W-1:0]       exact_cls
);

   // Scan from the largest class down so the smallest fitting class wins.
   always_comb begin
      logic [SCBR_SIZE_W:0] lim;
      logic [SCBR_SIZE_W:0] size_ext;
      size_ext    = {1'b0, size};
      fit_found   = 1'b0;
      fit_cls     = '0;
      fit_bytes   = '0;
      exact_found = 1'b0;
      exact_cls   = '0;
      for (int p = MAX_CLASS_POWER; p >= MIN_CLASS_POWER; p--) begin
         lim = (SCBR_SIZE_W+1)'(1) << p;
         if (size_ext <= lim) begin
            fit_found = 1'b1;
            fit_cls   = CLS_W'(p - MIN_CLASS_POWER);
            fit_bytes = lim[SCBR_SIZE_W-1:0];
         end
         if (size_ext == lim) begin
            exact_found = 1'b1;
            exact_cls   = CLS_W'(p - MIN_CLASS_POWER);
         end
      end
   end

endmodule

### hdl/scbr_pool_store.sv
// Class stack store: handle memory plus per-class fill levels.
`include "size_class_buffer_recycler_core_defines.svh"

module scbr_pool_store
   import scbr_pkg::*;
#(
   parameter int NUM_CLASSES = 21,
   parameter int STACK_DEPTH = SCBR_STACK_DEPTH,
   parameter int CLS_W       = 5,
   parameter int DATA_W      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  store_cmd_type     cmd,
   input  logic [CLS_W-1:0]  cls,
   input  logic [DATA_W-1:0] handle,
   output store_stat_type    stat,
   output logic [DATA_W-1:0] rd_data
);

   localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int FILL_W    = $clog2(STACK_DEPTH + 1);

   logic [FILL_W-1:0] fill_ff [NUM_CLASSES];
   logic [FILL_W-1:0] fill_in [NUM_CLASSES];
   logic [FILL_W-1:0] fill_cur;
   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] push_addr;
   logic [ADDR_W-1:0] pop_addr;
   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Occupancy of the addressed class.
   assign fill_cur       = fill_ff[cls];
   assign stat.has_entry = (fill_cur != '0);
   assign stat.has_room  = (fill_cur < FILL_W'(STACK_DEPTH));

   // Each class owns a contiguous row of STACK_DEPTH entries.
   assign base_addr = ADDR_W'(cls) * ADDR_W'(STACK_DEPTH);
   assign push_addr = base_addr + ADDR_W'(fill_cur);
   assign pop_addr  = push_addr - ADDR_W'(1);

   // Fill level moves by one on a push or a pop.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.push) begin
         fill_in[cls] = fill_cur + FILL_W'(1);
      end else if (cmd.pop) begin
         fill_in[cls] = fill_cur - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Handle memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[push_addr] <= handle;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[pop_addr];
      end
   end

   assign rd_data = rd_data_ff;

   `SCBR_ASSERT_IMPL(a_one_op, cmd.push || cmd.pop, cmd.push != cmd.pop, "push and pop together")
   `SCBR_ASSERT_IMPL(a_pop_has_entry, cmd.pop, stat.has_entry, "pop from an empty class")
   `SCBR_ASSERT_IMPL(a_push_has_room, cmd.push, stat.has_room, "push into a full class")
   `SCBR_ASSERT_NEXT(a_pop_fill, cmd.pop, fill_ff[$past(cls)] == $past(fill_cur) - 1'b1, "fill not decremented")

endmodule

### hdl/size_class_buffer_recycler_core.sv
// Top level of the size class buffer recycler: handshake, counters and result register.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  opcode, request_size, buffer_handle,
//                                            handle_class_size
//   rsp      out        rsp_valid/rsp_ready  status, class_size, granted_handle,
//                                            four 32-bit counters
//
// On the accept edge the fill level, the counters and the handle memory update; the
// result register loads later from the memory's registered read port, once the output
// register is free. A new item is accepted only after the last one has loaded it.
// Reset clears the fill levels directly; there is no clearing pass.
// While a result waits, one more item can be accepted; its result then holds in the
// read register until the output register frees up.
module size_class_buffer_recycler_core
   import scbr_pkg::*;
#(
   parameter int MIN_CLASS_POWER = SCBR_MIN_CLASS_POWER,
   parameter int MAX_CLASS_POWER = SCBR_MAX_CLASS_POWER,
   parameter int STACK_DEPTH     = SCBR_STACK_DEPTH,
   parameter int HANDLE_WIDTH    = SCBR_HANDLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [SCBR_SIZE_W-1:0]        req_request_size,
   input  logic [SCBR_HANDLE_PORT_W-1:0] req_buffer_handle,
   input  logic [SCBR_SIZE_W-1:0]        req_handle_class_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [SCBR_SIZE_W-1:0]        rsp_class_size,
   output logic [SCBR_HANDLE_PORT_W-1:0] rsp_granted_handle,
   output logic [SCBR_COUNT_W-1:0]       rsp_acquire_count,
   output logic [SCBR_COUNT_W-1:0]       rsp_hit_count,
   output logic [SCBR_COUNT_W-1:0]       rsp_miss_count,
   output logic [SCBR_COUNT_W-1:0]       rsp_release_count
);

   localparam int NUM_CLASSES = MAX_CLASS_POWER - MIN_CLASS_POWER + 1;
   localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int DATA_W      = (HANDLE_WIDTH < SCBR_HANDLE_PORT_W) ?
                                HANDLE_WIDTH : SCBR_HANDLE_PORT_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic                          accept;
   logic                          out_free;
   logic [SCBR_SIZE_W-1:0]        size_sel;
   logic [DATA_W-1:0]             handle_kept;
   logic                          fit_found, exact_found;
   logic [CLS_W-1:0]              fit_cls, exact_cls, cls;
   logic [SCBR_SIZE_W-1:0]        fit_bytes;
   store_cmd_type                 cmd;
   store_stat_type                stat;
   logic [DATA_W-1:0]             rd_data;
   status_type                    status_now;
   logic [SCBR_SIZE_W-1:0]        csize_now;
   status_type                    status_ff;
   logic [SCBR_SIZE_W-1:0]        csize_ff;
   logic [SCBR_COUNT_W-1:0]       acq_ff, hit_ff, miss_ff, rel_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [2:0]                    rsp_status_ff;
   logic [SCBR_SIZE_W-1:0]        rsp_class_size_ff;
   logic [SCBR_HANDLE_PORT_W-1:0] rsp_granted_ff;
   logic [SCBR_COUNT_W-1:0]       rsp_acq_ff, rsp_hit_ff, rsp_miss_ff, rsp_rel_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Release items decode their given class size, acquires the requested size.
   assign size_sel    = req_opcode ? req_handle_class_size : req_request_size;
   assign handle_kept = req_buffer_handle[DATA_W-1:0];
   assign cls         = req_opcode ? exact_cls : fit_cls;

   scbr_class_decode #(
      .MIN_CLASS_POWER (MIN_CLASS_POWER),
      .MAX_CLASS_POWER (MAX_CLASS_POWER),
      .CLS_W           (CLS_W)
   ) u_decode (
      .size        (size_sel),
      .fit_found   (fit_found),
      .fit_cls     (fit_cls),
      .fit_bytes   (fit_bytes),
      .exact_found (exact_found),
      .exact_cls   (exact_cls)
   );

   // Decide the outcome of the item at the input and issue the stack operation.
   always_comb begin
      cmd = '0;
      if (!req_opcode) begin
         if (!fit_found) begin
            status_now = STATUS_BYPASS;
            csize_now  = req_request_size;
         end else begin
            csize_now = fit_bytes;
            if (stat.has_entry) begin
               status_now = STATUS_HIT;
               cmd.pop    = accept;
            end else begin
               status_now = STATUS_MISS;
            end
         end
      end else begin
         csize_now = req_handle_class_size;
         if (handle_kept == '0) begin
            status_now = STATUS_NULL;
         end else if (exact_found && stat.has_room) begin
            status_now = STATUS_STORED;
            cmd.push   = accept;
         end else begin
            status_now = STATUS_DROPPED;
         end
      end
   end

   scbr_pool_store #(
      .NUM_CLASSES (NUM_CLASSES),
      .STACK_DEPTH (STACK_DEPTH),
      .CLS_W       (CLS_W),
      .DATA_W      (DATA_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .cls     (cls),
      .handle  (handle_kept),
      .stat    (stat),
      .rd_data (rd_data)
   );

   // Wrapping event counters, updated on the accept edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         acq_ff  <= '0;
         hit_ff  <= '0;
         miss_ff <= '0;
         rel_ff  <= '0;
      end else if (accept) begin
         if (!req_opcode) begin
            acq_ff <= acq_ff + SCBR_COUNT_W'(1);
         end
         if (status_now == STATUS_HIT) begin
            hit_ff <= hit_ff + SCBR_COUNT_W'(1);
         end
         if (status_now inside {STATUS_MISS, STATUS_BYPASS}) begin
            miss_ff <= miss_ff + SCBR_COUNT_W'(1);
         end
         if (req_opcode && handle_kept != '0) begin
            rel_ff <= rel_ff + SCBR_COUNT_W'(1);
         end
      end
   end

   // Outcome of the item in flight, held until the result register loads.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_now;
         csize_ff  <= csize_now;
      end
   end

   // Sequencer: accept, then wait for the result register.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == ST_READ && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ && out_free) begin
         rsp_status_ff     <= status_ff;
         rsp_class_size_ff <= csize_ff;
         rsp_granted_ff    <= (status_ff == STATUS_HIT) ?
                              SCBR_HANDLE_PORT_W'(rd_data) : '0;
         rsp_acq_ff        <= acq_ff;
         rsp_hit_ff        <= hit_ff;
         rsp_miss_ff       <= miss_ff;
         rsp_rel_ff        <= rel_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_class_size     = rsp_class_size_ff;
   assign rsp_granted_handle = rsp_granted_ff;
   assign rsp_acquire_count  = rsp_acq_ff;
   assign rsp_hit_count      = rsp_hit_ff;
   assign rsp_miss_count     = rsp_miss_ff;
   assign rsp_release_count  = rsp_rel_ff;

endmodule

### tb/tb_size_class_buffer_recycler_core.sv
// Self-checking testbench for the size class buffer recycler core.
`timescale 1ns / 100ps

module tb_size_class_buffer_recycler_core
   import scbr_pkg::*;
();

   // Opcode values of the request channel.
   localparam bit OP_ACQUIRE = 1'b0;
   localparam bit OP_RELEASE = 1'b1;

   localparam int NUM_CLASSES = SCBR_MAX_CLASS_POWER - SCBR_MIN_CLASS_POWER + 1;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 20;

   // One response item as seen on the rsp_ ports.
   typedef struct {
      logic [2:0]                    status;
      logic [SCBR_SIZE_W-1:0]        class_size;
      logic [SCBR_HANDLE_PORT_W-1:0] granted_handle;
      logic [SCBR_COUNT_W-1:0]       acquire_count;
      logic [SCBR_COUNT_W-1:0]       hit_count;
      logic [SCBR_COUNT_W-1:0]       miss_count;
      logic [SCBR_COUNT_W-1:0]       release_count;
   } pool_response_type;

   // Tracks the pool contents and queues the response each accepted request must produce.
   class pool_tracker;
      bit [SCBR_HANDLE_WIDTH-1:0] class_stack[NUM_CLASSES][SCBR_STACK_DEPTH];
      int unsigned class_fill[NUM_CLASSES];
      bit [SCBR_COUNT_W-1:0] acquires;
      bit [SCBR_COUNT_W-1:0] hits;
      bit [SCBR_COUNT_W-1:0] misses;
      bit [SCBR_COUNT_W-1:0] releases;
      pool_response_type pending_responses[$];
      int unsigned error_count;

      // Smallest class that holds the request, or -1 when it is oversize.
      function int class_for_request(bit [SCBR_SIZE_W-1:0] size);
         for (int p = SCBR_MIN_CLASS_POWER; p <= SCBR_MAX_CLASS_POWER; p++) begin
            if ((64'd1 << p) >= 64'(size)) return p - SCBR_MIN_CLASS_POWER;
         end
         return -1;
      endfunction

      // Class whose size matches exactly, or -1 when it is not a pool class.
      function int class_for_exact(bit [SCBR_SIZE_W-1:0] size);
         for (int p = SCBR_MIN_CLASS_POWER; p <= SCBR_MAX_CLASS_POWER; p++) begin
            if ((64'd1 << p) == 64'(size)) return p - SCBR_MIN_CLASS_POWER;
         end
         return -1;
      endfunction

      function void note_request(bit opcode, bit [SCBR_SIZE_W-1:0] size,
                                 bit [SCBR_HANDLE_PORT_W-1:0] handle,
                                 bit [SCBR_SIZE_W-1:0] handle_size);
         pool_response_type r;
         int c;
         bit [SCBR_HANDLE_WIDTH-1:0] kept;
         kept = handle[SCBR_HANDLE_WIDTH-1:0];
         r.granted_handle = '0;
         if (opcode == OP_ACQUIRE) begin
            acquires++;
            c = class_for_request(size);
            if (c < 0) begin
               // Oversize requests skip the pool and report the exact size.
               misses++;
               r.status = STATUS_BYPASS;
               r.class_size = size;
            end else begin
               r.class_size = 32'd1 << (c + SCBR_MIN_CLASS_POWER);
               if (class_fill[c] > 0) begin
                  class_fill[c]--;
                  r.granted_handle = SCBR_HANDLE_PORT_W'(class_stack[c][class_fill[c]]);
                  hits++;
                  r.status = STATUS_HIT;
               end else begin
                  misses++;
                  r.status = STATUS_MISS;
               end
            end
         end else begin
            r.class_size = handle_size;
            if (kept == '0) begin
               r.status = STATUS_NULL;
            end else begin
               releases++;
               c = class_for_exact(handle_size);
               if (c >= 0 && class_fill[c] < SCBR_STACK_DEPTH) begin
                  class_stack[c][class_fill[c]] = kept;
                  class_fill[c]++;
                  r.status = STATUS_STORED;
               end else begin
                  r.status = STATUS_DROPPED;
               end
            end
         end
         r.acquire_count = acquires;
         r.hit_count = hits;
         r.miss_count = misses;
         r.release_count = releases;
         pending_responses.insert(pending_responses.size(), r);
      endfunction

      function void check_response(pool_response_type got);
         pool_response_type want;
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding: status %0d", got.status);
            error_count++;
            return;
         end
         want = pending_responses.pop_front();
         if (got.status !== want.status) begin
            $error("rsp_status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.class_size !== want.class_size) begin
            $error("rsp_class_size: expected %0h, got %0h", want.class_size, got.class_size);
            error_count++;
         end
         if (got.granted_handle !== want.granted_handle) begin
            $error("rsp_granted_handle: expected %0h, got %0h",
                   want.granted_handle, got.granted_handle);
            error_count++;
         end
         if (got.acquire_count !== want.acquire_count) begin
            $error("rsp_acquire_count: expected %0d, got %0d",
                   want.acquire_count, got.acquire_count);
            error_count++;
         end
         if (got.hit_count !== want.hit_count) begin
            $error("rsp_hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
            error_count++;
         end
         if (got.miss_count !== want.miss_count) begin
            $error("rsp_miss_count: expected %0d, got %0d", want.miss_count, got.miss_count);
            error_count++;
         end
         if (got.release_count !== want.release_count) begin
            $error("rsp_release_count: expected %0d, got %0d",
                   want.release_count, got.release_count);
            error_count++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_opcode = OP_ACQUIRE;
   logic [SCBR_SIZE_W-1:0]        req_request_size = '0;
   logic [SCBR_HANDLE_PORT_W-1:0] req_buffer_handle = '0;
   logic [SCBR_SIZE_W-1:0]        req_handle_class_size = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [2:0]                    rsp_status;
   logic [SCBR_SIZE_W-1:0]        rsp_class_size;
   logic [SCBR_HANDLE_PORT_W-1:0] rsp_granted_handle;
   logic [SCBR_COUNT_W-1:0]       rsp_acquire_count;
   logic [SCBR_COUNT_W-1:0]       rsp_hit_count;
   logic [SCBR_COUNT_W-1:0]       rsp_miss_count;
   logic [SCBR_COUNT_W-1:0]       rsp_release_count;

   pool_tracker tracker = new;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   bit hold_request = 1'b0;

   size_class_buffer_recycler_core DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_request_size      (req_request_size),
      .req_buffer_handle     (req_buffer_handle),
      .req_handle_class_size (req_handle_class_size),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_class_size        (rsp_class_size),
      .rsp_granted_handle    (rsp_granted_handle),
      .rsp_acquire_count     (rsp_acquire_count),
      .rsp_hit_count         (rsp_hit_count),
      .rsp_miss_count        (rsp_miss_count),
      .rsp_release_count     (rsp_release_count)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check each accepted item, then pick ready for the next cycle.
   initial begin
      pool_response_type got;
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.class_size = rsp_class_size;
            got.granted_handle = rsp_granted_handle;
            got.acquire_count = rsp_acquire_count;
            got.hit_count = rsp_hit_count;
            got.miss_count = rsp_miss_count;
            got.release_count = rsp_release_count;
            tracker.check_response(got);
         end
         // A long hold-off lets the block fill up and back-pressure the request side.
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one item and wait for it to be accepted; valid stays high afterwards.
   task automatic send_request(bit opcode, bit [SCBR_SIZE_W-1:0] size,
                               bit [SCBR_HANDLE_PORT_W-1:0] handle,
                               bit [SCBR_SIZE_W-1:0] handle_size);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_request_size <= size;
      req_buffer_handle <= handle;
      req_handle_class_size <= handle_size;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(opcode, size, handle, handle_size);
   endtask

   // Drop valid and wait until every outstanding response has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_responses.size() != 0);
   endtask

   // Mostly the small classes, so that stacks fill and hits are frequent.
   function automatic int pick_class_power();
      if ($urandom_range(99) < 75)
         return $urandom_range(SCBR_MIN_CLASS_POWER + 3, SCBR_MIN_CLASS_POWER);
      return $urandom_range(SCBR_MAX_CLASS_POWER, SCBR_MIN_CLASS_POWER);
   endfunction

   // Random item: mostly well-formed acquires and releases, some malformed ones.
   task automatic send_random_request();
      int p;
      int unsigned pick;
      bit [SCBR_SIZE_W-1:0] size;
      bit [SCBR_HANDLE_PORT_W-1:0] handle;
      bit [SCBR_SIZE_W-1:0] handle_size;
      p = pick_class_power();
      pick = $urandom_range(99);
      size = $urandom();
      handle = SCBR_HANDLE_PORT_W'($urandom());
      handle_size = $urandom();
      if ($urandom_range(99) < 48) begin
         if (pick < 60) begin
            if (p == SCBR_MIN_CLASS_POWER) size = $urandom_range(32'd1 << p, 0);
            else size = $urandom_range(32'd1 << p, (32'd1 << (p - 1)) + 1);
         end else if (pick < 75) begin
            size = 32'd1 << p;
         end else if (pick < 88) begin
            size = $urandom();
         end else if (pick < 94) begin
            size = (32'd1 << SCBR_MAX_CLASS_POWER) + $urandom_range(3, 0);
         end else begin
            size = 0;
         end
         send_request(OP_ACQUIRE, size, handle, handle_size);
      end else begin
         if ($urandom_range(99) < 95) begin
            handle = SCBR_HANDLE_PORT_W'($urandom_range(16'hFFFF, 1));
         end else begin
            handle = '0;
         end
         if (pick < 80) begin
            handle_size = 32'd1 << p;
         end else if (pick < 88) begin
            handle_size = $urandom();
         end else if (pick < 94) begin
            handle_size = $urandom_range(1, 0) ? (32'd1 << p) + 1 : (32'd1 << p) - 1;
         end else if (pick < 97) begin
            handle_size = 32'd1 << $urandom_range(SCBR_MIN_CLASS_POWER - 1, 0);
         end else begin
            handle_size = 32'd1 << $urandom_range(31, SCBR_MAX_CLASS_POWER + 1);
         end
         send_request(OP_RELEASE, size, handle, handle_size);
      end
   endtask

   // Stimulus: directed cases first, then random phases with varying idle patterns.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: size extremes, oversize, null and malformed releases, stack overflow.
      send_request(OP_ACQUIRE, 32'd0, 16'h0000, 32'd0);
      send_request(OP_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(OP_ACQUIRE, 32'd1 << SCBR_MAX_CLASS_POWER, 16'h0001, 32'd0);
      send_request(OP_ACQUIRE, (32'd1 << SCBR_MAX_CLASS_POWER) + 1, 16'h0000, 32'd0);
      send_request(OP_ACQUIRE, 32'd257, 16'h0000, 32'd0);
      send_request(OP_RELEASE, 32'd0, 16'h0000, 32'd256);
      send_request(OP_RELEASE, 32'hFFFF_FFFF, 16'hFFFF, 32'd256);
      send_request(OP_ACQUIRE, 32'd1, 16'h0000, 32'd0);
      send_request(OP_RELEASE, 32'd0, 16'h1234, 32'd300);
      send_request(OP_RELEASE, 32'd0, 16'h0001, 32'd128);
      send_request(OP_RELEASE, 32'd0, 16'h8000, 32'd1 << (SCBR_MAX_CLASS_POWER + 1));
      send_request(OP_RELEASE, 32'd0, 16'h0005, 32'd0);
      send_request(OP_RELEASE, 32'd0, 16'hA5A5, 32'd1 << SCBR_MAX_CLASS_POWER);
      send_request(OP_ACQUIRE, (32'd1 << (SCBR_MAX_CLASS_POWER - 1)) + 1, 16'h0000, 32'd0);
      for (int i = 0; i <= SCBR_STACK_DEPTH; i++) begin
         send_request(OP_RELEASE, 32'd0, 16'h0100 + 16'(i), 32'd512);
      end
      send_request(OP_ACQUIRE, 32'd512, 16'h0000, 32'd0);
      pause_until_drained();

      // No idling; a long response hold-off midway, and a drain pause.
      for (int i = 0; i < 110; i++) begin
         if (i == 40) hold_request = 1'b1;
         if (i == 80) pause_until_drained();
         send_random_request();
      end
      pause_until_drained();

      // Sender mostly idle.
      idle_pct = 87;
      for (int i = 0; i < 90; i++) send_random_request();

      // Receiver mostly stalling.
      idle_pct = 0;
      stall_pct = 87;
      for (int i = 0; i < 90; i++) send_random_request();

      // Light idling on both sides.
      idle_pct = 8;
      stall_pct = 8;
      for (int i = 0; i < 135; i++) send_random_request();

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("tb_size_class_buffer_recycler_core: PASS");
      end else begin
         $display("tb_size_class_buffer_recycler_core: FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("tb_size_class_buffer_recycler_core: FAIL");
      $finish;
   end

endmodule
